### src/bnv_pkg.sv
`default_nettype none

package bnv_pkg;

	// deepest block nesting the stack holds
	localparam int MAX_NESTING = 16;

	// opcodes that steer the block structure
	localparam logic [7:0] OP_NONE  = 8'd0;
	localparam logic [7:0] OP_IF    = 8'd4;
	localparam logic [7:0] OP_BEGIN = 8'd13;
	localparam logic [7:0] OP_ELSE  = 8'd14;
	localparam logic [7:0] OP_END   = 8'd15;
	localparam logic [7:0] OP_LAST  = 8'd28;

	// highest legal operand kind
	localparam logic [7:0] KIND_LAST = 8'd3;

	typedef enum logic [1:0] {
		BK_GENERIC = 2'd0,
		BK_IF_TRUE = 2'd1,
		BK_IF_ELSE = 2'd2
	} bnv_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD       = 3'd1,
		ERR_UNMATCHED = 3'd2,
		ERR_ELSE      = 3'd3,
		ERR_UNCLOSED  = 3'd4,
		ERR_OVERFLOW  = 3'd5
	} bnv_err_t;

	// command broadcast to every stack cell
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} bnv_stack_cmd_t;

	// status seen at the ends of the cell row
	typedef struct packed {
		bnv_kind_t top_kind;
		logic      nonempty;
		logic      full;
	} bnv_stack_sts_t;

endpackage

`default_nettype wire

### src/bnv_rec_if.sv
`default_nettype none

interface bnv_rec_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] opcode;
	logic [7:0] kind_code;

	modport source (output valid, req_type, opcode, kind_code, input ready);
	modport sink (input valid, req_type, opcode, kind_code, output ready);
endinterface

`default_nettype wire

### src/bnv_rpt_if.sv
`default_nettype none

interface bnv_rpt_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [2:0] error_code;

	modport source (output valid, valid_res, error_code, input ready);
	modport sink (input valid, valid_res, error_code, output ready);
endinterface

`default_nettype wire

### src/block_nesting_validator.sv
`default_nettype none

// Block nesting validator.
// rec channel: one transaction per instruction record (req_type 0, opcode,
// kind_code) or per end-of-stream request (req_type 1).
// rpt channel: one transaction per end-of-stream request, carrying
// valid_res and error_code (first error seen, or unclosed blocks).
// Records give no report transaction.
// Throughput: one transaction per cycle on rec while no end-of-stream request
// waits; each record updates the block stack (a row of MAX_NESTING shift cells).
// The report appears on rpt in the cycle after its request is taken.
// A record is taken even while a report waits; an end-of-stream request
// waits only while the report register is full and rpt is stalled.
// The report clears the stack, the pending kind, the else flag and the
// error so the next stream starts fresh.
// Reset (arst_n low) empties the stack and the report register and clears
// all flags; no clearing pass is needed.
module block_nesting_validator
	import bnv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bnv_rec_if.sink   rec,
	bnv_rpt_if.source rpt
);

	bnv_kind_t      pend_q, pend_d;
	logic           else_q, else_d;
	bnv_err_t       err_q, err_d, code;
	bnv_stack_cmd_t cmd;
	bnv_stack_sts_t sts;
	logic           rpt_valid_q;
	logic           rpt_ok_q;
	bnv_err_t       rpt_code_q;
	logic           rec_fire, rpt_fire, active, bad;

	// records never block; a report request waits for a free output slot
	assign rec.ready = !rec.req_type || !rpt_valid_q || rpt.ready;
	assign rec_fire  = rec.valid && rec.ready && !rec.req_type;
	assign rpt_fire  = rec.valid && rec.ready && rec.req_type;
	assign active    = rec_fire && (err_q == ERR_NONE);
	assign bad       = (rec.opcode == OP_NONE) || (rec.opcode > OP_LAST) ||
	                   (rec.kind_code > KIND_LAST);

	// record decode and next state
	always_comb begin
		pend_d = pend_q;
		else_d = else_q;
		err_d  = err_q;
		cmd    = '0;
		if (rpt_fire) begin
			pend_d    = BK_GENERIC;
			else_d    = 1'b0;
			err_d     = ERR_NONE;
			cmd.clear = 1'b1;
		end else if (active) begin
			if (bad) begin
				err_d = ERR_BAD;
			end else begin
				case (rec.opcode)
					OP_IF: begin
						pend_d = BK_IF_TRUE;
						else_d = 1'b0;
					end
					OP_BEGIN: begin
						if (sts.full) begin
							err_d = ERR_OVERFLOW;
						end else begin
							cmd.push = 1'b1;
							pend_d   = BK_GENERIC;
							else_d   = 1'b0;
						end
					end
					OP_END: begin
						if (!sts.nonempty) begin
							err_d = ERR_UNMATCHED;
						end else begin
							cmd.pop = 1'b1;
							else_d  = (sts.top_kind == BK_IF_TRUE);
						end
					end
					OP_ELSE: begin
						if (!else_q) begin
							err_d = ERR_ELSE;
						end else begin
							pend_d = BK_IF_ELSE;
							else_d = 1'b0;
						end
					end
					default: begin
						pend_d = BK_GENERIC;
						else_d = 1'b0;
					end
				endcase
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= BK_GENERIC;
			else_q <= 1'b0;
			err_q  <= ERR_NONE;
		end else begin
			pend_q <= pend_d;
			else_q <= else_d;
			err_q  <= err_d;
		end
	end

	bnv_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_kind (pend_q),
		.sts       (sts)
	);

	// final verdict of the stream
	assign code = (err_q != ERR_NONE) ? err_q :
	              (sts.nonempty ? ERR_UNCLOSED : ERR_NONE);

	// report output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (rpt_fire) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_fire) begin
			rpt_ok_q   <= (code == ERR_NONE);
			rpt_code_q <= code;
		end
	end

	assign rpt.valid      = rpt_valid_q;
	assign rpt.valid_res  = rpt_ok_q;
	assign rpt.error_code = rpt_code_q;

endmodule

`default_nettype wire

### src/bnv_cell.sv
`default_nettype none

module bnv_cell
	import bnv_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bnv_stack_cmd_t cmd,
	input  wire bnv_kind_t      up_kind,
	input  wire logic           up_occ,
	input  wire bnv_kind_t      dn_kind,
	input  wire logic           dn_occ,
	output bnv_kind_t           kind,
	output logic                occ
);

	bnv_kind_t kind_q;
	logic      occ_q;

	// occupancy, a thermometer code of the stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.clear) begin
			occ_q <= 1'b0;
		end else if (cmd.push) begin
			occ_q <= up_occ;
		end else if (cmd.pop) begin
			occ_q <= dn_occ;
		end
	end

	// block kind shifts with the occupancy
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kind_q <= up_kind;
		end else if (cmd.pop) begin
			kind_q <= dn_kind;
		end
	end

	assign kind = kind_q;
	assign occ  = occ_q;

endmodule

`default_nettype wire

### src/bnv_stack.sv
`default_nettype none

module bnv_stack
	import bnv_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bnv_stack_cmd_t cmd,
	input  wire bnv_kind_t      push_kind,
	output bnv_stack_sts_t      sts
);

	bnv_kind_t cell_kind [MAX_NESTING];
	logic      cell_occ  [MAX_NESTING];

	// cell 0 is the top of stack; push shifts down the row, pop shifts up
	for (genvar i = 0; i < MAX_NESTING; i++) begin : g_cell
		bnv_kind_t up_kind;
		logic      up_occ;
		bnv_kind_t dn_kind;
		logic      dn_occ;

		if (i == 0) begin : g_top
			assign up_kind = push_kind;
			assign up_occ  = 1'b1;
		end else begin : g_mid
			assign up_kind = cell_kind[i-1];
			assign up_occ  = cell_occ[i-1];
		end

		if (i == MAX_NESTING - 1) begin : g_bot
			assign dn_kind = BK_GENERIC;
			assign dn_occ  = 1'b0;
		end else begin : g_inner
			assign dn_kind = cell_kind[i+1];
			assign dn_occ  = cell_occ[i+1];
		end

		bnv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.up_kind (up_kind),
			.up_occ  (up_occ),
			.dn_kind (dn_kind),
			.dn_occ  (dn_occ),
			.kind    (cell_kind[i]),
			.occ     (cell_occ[i])
		);
	end

	assign sts.top_kind = cell_kind[0];
	assign sts.nonempty = cell_occ[0];
	assign sts.full     = cell_occ[MAX_NESTING-1];

endmodule

`default_nettype wire

### verif/tb_block_nesting_validator.sv
`default_nettype none

module tb_block_nesting_validator;
	import bnv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// request types on the record channel
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	// a plain opcode that touches no block structure
	localparam logic [7:0] OP_PLAIN = 8'd1;

	localparam int CYCLE_LIMIT = 500000;

	typedef enum int {
		STREAM_CLEAN,
		STREAM_BROKEN,
		STREAM_DEEP
	} stream_mode_t;

	typedef struct packed {
		logic     valid_res;
		bnv_err_t code;
	} nesting_report_t;

	logic clk;
	logic arst_n;

	bnv_rec_if rec_bus ();
	bnv_rpt_if rpt_bus ();

	block_nesting_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_bus),
		.rpt    (rpt_bus)
	);

	// shadow of the block state, advanced on every accepted transaction
	bnv_kind_t shadow_stack [MAX_NESTING];
	int        shadow_depth;
	bnv_kind_t shadow_pending;
	bit        shadow_else_ok;
	bnv_err_t  shadow_error;

	nesting_report_t awaited_reports [$];

	int  mismatch_count;
	int  live_items;
	int  cycle_count;
	int  ready_hold;
	bit  ready_quiet;
	bit  send_quiet;
	bit  no_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic shadow_clear();
		shadow_depth   = 0;
		shadow_pending = BK_GENERIC;
		shadow_else_ok = 1'b0;
		shadow_error   = ERR_NONE;
	endtask

	// work out the effect of one accepted transaction on the block
	task automatic nesting_update(input logic req, input logic [7:0] op,
		input logic [7:0] kind);
		nesting_report_t rep;
		if (req == REQ_REPORT) begin
			rep.code = shadow_error;
			if (rep.code == ERR_NONE && shadow_depth != 0)
				rep.code = ERR_UNCLOSED;
			rep.valid_res = (rep.code == ERR_NONE);
			awaited_reports.insert(awaited_reports.size(), rep);
			shadow_clear();
		end else if (shadow_error == ERR_NONE) begin
			if (op == OP_NONE || op > OP_LAST || kind > KIND_LAST) begin
				shadow_error = ERR_BAD;
			end else if (op == OP_IF) begin
				shadow_pending = BK_IF_TRUE;
				shadow_else_ok = 1'b0;
			end else if (op == OP_BEGIN) begin
				if (shadow_depth >= MAX_NESTING) begin
					shadow_error = ERR_OVERFLOW;
				end else begin
					shadow_stack[shadow_depth] = shadow_pending;
					shadow_depth++;
					shadow_pending = BK_GENERIC;
					shadow_else_ok = 1'b0;
				end
			end else if (op == OP_END) begin
				// the pending kind survives an end
				if (shadow_depth == 0) begin
					shadow_error = ERR_UNMATCHED;
				end else begin
					shadow_depth--;
					shadow_else_ok = (shadow_stack[shadow_depth] == BK_IF_TRUE);
				end
			end else if (op == OP_ELSE) begin
				if (!shadow_else_ok) begin
					shadow_error = ERR_ELSE;
				end else begin
					shadow_pending = BK_IF_ELSE;
					shadow_else_ok = 1'b0;
				end
			end else begin
				shadow_pending = BK_GENERIC;
				shadow_else_ok = 1'b0;
			end
		end
	endtask

	// drive one transaction, with an optional idle burst ahead of it
	task automatic send_item(input logic req, input logic [7:0] op,
		input logic [7:0] kind);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 149) == 0)
			send_quiet = !send_quiet;
		if (!no_idle && !send_quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			rec_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rec_bus.valid     <= 1'b1;
		rec_bus.req_type  <= req;
		rec_bus.opcode    <= op;
		rec_bus.kind_code <= kind;
		do
			@(posedge clk);
		while (rec_bus.ready !== 1'b1);
		nesting_update(req, op, kind);
		live_items++;
	endtask

	task automatic send_record(input logic [7:0] op, input logic [7:0] kind);
		send_item(REQ_RECORD, op, kind);
	endtask

	task automatic send_report();
		send_item(REQ_REPORT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// hold the record channel until every report has arrived
	task automatic wait_drained();
		@(negedge clk);
		rec_bus.valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	// report channel: random stall bursts, with quiet stretches
	always @(negedge clk) begin
		if (no_idle || !arst_n) begin
			rpt_bus.ready <= arst_n;
		end else begin
			if ($urandom_range(0, 299) == 0)
				ready_quiet = !ready_quiet;
			if (ready_hold > 0) begin
				ready_hold--;
				rpt_bus.ready <= 1'b0;
			end else if (!ready_quiet && $urandom_range(0, 5) == 0) begin
				ready_hold = $urandom_range(1, 12) - 1;
				rpt_bus.ready <= 1'b0;
			end else begin
				rpt_bus.ready <= 1'b1;
			end
		end
	end

	// compare each report transaction with the oldest awaited one
	always @(posedge clk) begin
		nesting_report_t exp_rep;
		if (arst_n && rpt_bus.valid === 1'b1 && rpt_bus.ready === 1'b1) begin
			if (awaited_reports.size() == 0) begin
				flag_mismatch($sformatf("report with none awaited: valid_res %0b code %0d",
					rpt_bus.valid_res, rpt_bus.error_code));
			end else begin
				exp_rep = awaited_reports.pop_front();
				if (rpt_bus.valid_res !== exp_rep.valid_res)
					flag_mismatch($sformatf("valid_res %0b, expected %0b",
						rpt_bus.valid_res, exp_rep.valid_res));
				if (rpt_bus.error_code !== exp_rep.code)
					flag_mismatch($sformatf("error_code %0d, expected %0d",
						rpt_bus.error_code, exp_rep.code));
			end
		end
	end

	// one random stream steered by the shadow state, then its report
	task automatic run_stream(input stream_mode_t mode, input int len);
		int         i;
		int         pick;
		logic [7:0] op;
		logic [7:0] kind;
		for (i = 0; i < len; i++) begin
			kind = 8'($urandom_range(0, 3));
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 4) begin
				// noise over the whole field range
				op   = 8'($urandom_range(0, 255));
				kind = 8'($urandom_range(0, 255));
			end else if (mode == STREAM_DEEP) begin
				if (shadow_depth < MAX_NESTING)
					op = (pick < 30) ? OP_IF : OP_BEGIN;
				else
					op = (pick < 30) ? OP_BEGIN : OP_END;
			end else begin
				if (pick < 20)
					op = OP_IF;
				else if (pick < 45)
					op = OP_BEGIN;
				else if (pick < 70)
					op = OP_END;
				else if (pick < 80)
					op = OP_ELSE;
				else
					op = 8'($urandom_range(1, 28));
				// keep clean streams well formed
				if (mode == STREAM_CLEAN) begin
					if (op == OP_BEGIN && shadow_depth >= MAX_NESTING)
						op = OP_END;
					else if (op == OP_END && shadow_depth == 0)
						op = OP_BEGIN;
					else if (op == OP_ELSE && !shadow_else_ok)
						op = OP_PLAIN;
				end
			end
			send_record(op, kind);
		end
		// close open blocks unless the stream should end unclosed
		if ($urandom_range(0, 99) < ((mode == STREAM_BROKEN) ? 50 : 90)) begin
			while (shadow_depth > 0 && shadow_error == ERR_NONE)
				send_record(OP_END, 8'($urandom_range(0, 3)));
		end
		send_report();
	endtask

	task automatic run_random_mix(input int item_goal);
		int           goal;
		int           pick;
		int           len;
		stream_mode_t mode;
		goal = live_items + item_goal;
		while (live_items < goal) begin
			pick = $urandom_range(0, 99);
			mode = (pick < 70) ? STREAM_CLEAN : (pick < 88) ? STREAM_BROKEN : STREAM_DEEP;
			if (mode == STREAM_DEEP)
				len = $urandom_range(16, 40);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 60);
			else
				len = $urandom_range(0, 12);
			run_stream(mode, len);
		end
	endtask

	// field extremes, every control opcode and each error kind but overflow
	task automatic test_directed_cases();
		// legal if / else chain ending on the last legal opcode
		send_record(OP_IF, 8'd0);
		send_record(OP_BEGIN, KIND_LAST);
		send_record(OP_END, 8'd0);
		send_record(OP_ELSE, 8'd2);
		send_record(OP_BEGIN, 8'd1);
		send_record(OP_END, 8'd0);
		send_record(OP_LAST, KIND_LAST);
		send_report();
		// pending kind kept across an end, so the else is legal
		send_record(OP_BEGIN, 8'd0);
		send_record(OP_IF, 8'd0);
		send_record(OP_END, 8'd0);
		send_record(OP_BEGIN, 8'd0);
		send_record(OP_END, 8'd0);
		send_record(OP_ELSE, 8'd0);
		send_item(REQ_REPORT, 8'hFF, 8'hFF);
		// zero opcode
		send_record(OP_NONE, 8'd0);
		send_report();
		// opcode past the last, then ignored records after the error
		send_record(8'hFF, 8'hFF);
		send_record(OP_END, 8'd0);
		send_report();
		// operand kind one past the last legal
		send_record(OP_PLAIN, KIND_LAST + 8'd1);
		send_report();
		// end on an empty stack
		send_record(OP_END, 8'd0);
		send_report();
		// else without permission
		send_record(OP_ELSE, 8'd0);
		send_report();
		// open block at the report
		send_record(OP_BEGIN, 8'd0);
		send_report();
	endtask

	// fill the stack to its limit, with and without overflow
	task automatic test_nesting_limit();
		int n;
		for (n = 0; n < 8; n++)
			run_stream(STREAM_DEEP, $urandom_range(16, 34));
	endtask

	task automatic test_random_streams();
		run_random_mix(1300);
	endtask

	// last part without any idling on either side
	task automatic test_back_to_back();
		no_idle = 1'b1;
		run_random_mix(400);
	endtask

	initial begin
		arst_n            = 1'b0;
		rec_bus.valid     = 1'b0;
		rec_bus.req_type  = REQ_RECORD;
		rec_bus.opcode    = 8'd0;
		rec_bus.kind_code = 8'd0;
		rpt_bus.ready     = 1'b0;
		mismatch_count    = 0;
		live_items        = 0;
		ready_hold        = 0;
		ready_quiet       = 1'b0;
		send_quiet        = 1'b0;
		no_idle           = 1'b0;
		shadow_clear();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		wait_drained();
		test_nesting_limit();
		test_random_streams();
		wait_drained();
		test_back_to_back();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && awaited_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
